>>> design/linear_probe_hash_table_macros.svh
// Assertion macros shared by the hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpht: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpht: next-cycle check failed");

`endif

>>> design/lpht_pkg.sv
// Shared types and constants of the linear probing hash table.
`timescale 1ns / 1ps

package lpht_pkg;

   // Field widths of the request and response items.
   localparam int KEY_W   = 31;
   localparam int VALUE_W = 32;
   localparam int SLOT_W  = 6;
   localparam int OCC_W   = 7;

   // Default number of slots in the table.
   localparam int DEFAULT_TABLE_SLOTS = 64;

   // Register file: byte address width and register index.
   localparam int   CSR_ADDR_W      = 3;
   localparam logic CSR_DELETE_MODE = 1'b0;

   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_FULL    = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HOME,
      S_WALK,
      S_CL_READ,
      S_CL_EVAL,
      S_MV_HOME,
      S_MV_WALK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] found_value;
      logic [OCC_W-1:0]   occupied;
   } rsp_type;

   // One slot of the table as it is stored.
   typedef struct packed {
      mark_type           mark;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

   // Write controls of the slot store.
   typedef struct packed {
      logic     mark_we;
      logic     kv_we;
      slot_type data;
   } slot_wr_type;

endpackage

>>> design/linear_probe_hash_table.sv
// Top level of the linear probing hash table with its register port.
// Open-addressing hash table of TABLE_SLOTS key/value slots that runs one request at a time
// (find, insert or remove) and returns one response per request. After reset the block clears
// its slot marks and holds req_stall high meanwhile; register writes are taken at any time.
// A request probes the slots from the home slot onward, one per cycle through the single read
// port of the slot memory; any slot count other than a power of two finds each home slot by
// reciprocal multiplication in a longer pipeline. A remove with delete_mode set then walks the
// rest of the cluster, reading and then evaluating each slot, and each entry moved back costs
// its home slot lookup plus its probe walk.
// The response register lets a request be accepted while the previous response still waits.
`timescale 1ns / 1ps

module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int AW = $clog2(TABLE_SLOTS);

   logic          delete_mode_ff, delete_mode_in;
   logic          csr_write;
   logic          home_start;
   logic [KEY_W-1:0] home_key;
   logic          home_done;
   logic [AW-1:0] home_addr;
   logic [AW-1:0] raddr;
   logic [AW-1:0] waddr;
   slot_type      rd;
   slot_wr_type   wr;

   // Register port: one register, written in the access phase.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      delete_mode_in = delete_mode_ff;
      if (csr_write && (paddr[CSR_ADDR_W-1] == CSR_DELETE_MODE)) begin
         delete_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delete_mode_ff <= 1'b0;
      end else begin
         delete_mode_ff <= delete_mode_in;
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_DELETE_MODE) ? {31'b0, delete_mode_ff} : 32'b0;

   lpht_home #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_home (
      .clock(clock),
      .reset(reset),
      .start(home_start),
      .key  (home_key),
      .done (home_done),
      .home (home_addr)
   );

   lpht_store #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_store (
      .clock(clock),
      .raddr(raddr),
      .rd   (rd),
      .waddr(waddr),
      .wr   (wr)
   );

   lpht_ctrl #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .delete_mode(delete_mode_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .home_start (home_start),
      .home_key   (home_key),
      .home_done  (home_done),
      .home_addr  (home_addr),
      .raddr      (raddr),
      .rd         (rd),
      .waddr      (waddr),
      .wr         (wr)
   );

endmodule

>>> design/lpht_home.sv
// Home slot unit: key modulo the table size.
`timescale 1ns / 1ps

module lpht_home
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [KEY_W-1:0]               key,
   output logic                           done,
   output logic [$clog2(TABLE_SLOTS)-1:0] home
);

   localparam int AW   = $clog2(TABLE_SLOTS);
   localparam bit POW2 = (TABLE_SLOTS == (1 << AW));

   generate
      if (POW2) begin : g_mask
         // A power of two size: the home slot is the low bits of the key.
         logic          done_ff;
         logic [AW-1:0] home_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               home_ff <= key[AW-1:0];
            end
         end

         assign done = done_ff;
         assign home = home_ff;
      end else begin : g_recip
         // Any other size: the quotient comes from a multiplication by the rounded-up
         // reciprocal, which is exact for every key of KEY_W bits, and the home slot is
         // the key less the quotient times the size, in step with stage1, stage2 and done.
         localparam int               SHIFT   = KEY_W + AW;
         localparam longint unsigned  RECIP   = ((64'd1 << SHIFT) + 64'(TABLE_SLOTS) - 64'd1)
                                                / 64'(TABLE_SLOTS);
         localparam logic [31:0]      MULT    = 32'(RECIP);
         localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_SLOTS);

         logic              stage1_ff;
         logic              stage2_ff;
         logic              done_ff;
         logic [KEY_W-1:0]  key1_ff;
         logic [KEY_W-1:0]  key2_ff;
         logic [KEY_W-1:0]  quot_ff, quot_in;
         logic [AW-1:0]     rem_ff, rem_in;
         logic [KEY_W+31:0] prod;
         logic [KEY_W-1:0]  diff;

         // Quotient by reciprocal multiplication, then the remainder by one subtraction.
         assign prod    = (KEY_W + 32)'(key1_ff) * (KEY_W + 32)'(MULT);
         assign quot_in = KEY_W'(prod >> SHIFT);
         assign diff    = key2_ff - quot_ff * DIVISOR;
         assign rem_in  = diff[AW-1:0];

         always_ff @(posedge clock) begin
            if (reset) begin
               stage1_ff <= 1'b0;
               stage2_ff <= 1'b0;
               done_ff   <= 1'b0;
            end else begin
               stage1_ff <= start;
               stage2_ff <= stage1_ff;
               done_ff   <= stage2_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               key1_ff <= key;
            end
            key2_ff <= key1_ff;
            quot_ff <= quot_in;
            rem_ff  <= rem_in;
         end

         assign done = done_ff;
         assign home = rem_ff;
      end
   endgenerate

endmodule

>>> design/lpht_store.sv
// Slot store: key/value memory and mark memory with registered reads.
`timescale 1ns / 1ps

module lpht_store
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
   input  logic                           clock,
   input  logic [$clog2(TABLE_SLOTS)-1:0] raddr,
   output slot_type                       rd,
   input  logic [$clog2(TABLE_SLOTS)-1:0] waddr,
   input  slot_wr_type                    wr
);

   localparam int KV_W = KEY_W + VALUE_W;

   logic [KV_W-1:0] kv_mem [TABLE_SLOTS];
   mark_type        mark_mem [TABLE_SLOTS];

   logic [KV_W-1:0] kv_rd_ff;
   mark_type        mark_rd_ff;

   // Key and value of each slot.
   always_ff @(posedge clock) begin
      if (wr.kv_we) begin
         kv_mem[waddr] <= {wr.data.key, wr.data.value};
      end
      kv_rd_ff <= kv_mem[raddr];
   end

   // Slot marks; cleared by the controller after reset.
   always_ff @(posedge clock) begin
      if (wr.mark_we) begin
         mark_mem[waddr] <= wr.data.mark;
      end
      mark_rd_ff <= mark_mem[raddr];
   end

   assign rd.mark  = mark_rd_ff;
   assign rd.key   = kv_rd_ff[KV_W-1:VALUE_W];
   assign rd.value = kv_rd_ff[VALUE_W-1:0];

endmodule

>>> design/lpht_ctrl.sv
// Operation sequencer: probe walks, updates, cluster rebuild and response register.
`timescale 1ns / 1ps

module lpht_ctrl
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           delete_mode,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  req_type                        req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rsp_type                        rsp_payload,
   output logic                           home_start,
   output logic [KEY_W-1:0]               home_key,
   input  logic                           home_done,
   input  logic [$clog2(TABLE_SLOTS)-1:0] home_addr,
   output logic [$clog2(TABLE_SLOTS)-1:0] raddr,
   input  slot_type                       rd,
   output logic [$clog2(TABLE_SLOTS)-1:0] waddr,
   output slot_wr_type                    wr
);

   localparam int            AW   = $clog2(TABLE_SLOTS);
   localparam int            CW   = $clog2(TABLE_SLOTS + 1);
   localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);

   state_type          state_ff, state_in;
   req_type            op_ff, op_in;
   logic [AW-1:0]      p_ff, p_in;
   logic [AW-1:0]      n_ff, n_in;
   logic [AW-1:0]      q_ff, q_in;
   logic [AW-1:0]      m_ff, m_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CW-1:0]      count_ff, count_in;
   slot_type           mv_ff, mv_in;
   status_type         res_status_ff, res_status_in;
   logic [AW-1:0]      res_slot_ff, res_slot_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic req_op_ok;
   logic hit_empty;
   logic hit_key;
   logic walk_last;
   logic cl_last;
   logic clr_last;
   logic rsp_free;

   // Next slot with wrap-around at the end of the table.
   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] a);
      return (a == LAST) ? '0 : a + AW'(1);
   endfunction

   assign req_op_ok = (req_payload.opcode == OP_FIND) || (req_payload.opcode == OP_INSERT) ||
                      (req_payload.opcode == OP_REMOVE);
   assign hit_empty = (rd.mark == MARK_EMPTY);
   assign hit_key   = (rd.mark == MARK_FULL) && (rd.key == op_ff.key);
   assign walk_last = (n_ff == LAST);
   assign cl_last   = (m_ff == LAST);
   assign clr_last  = (clr_ff == LAST);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = req_op_ok ? S_HOME : S_DONE;
            end
         end
         S_HOME: begin
            if (home_done) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (hit_empty) begin
               state_in = S_DONE;
            end else if (hit_key) begin
               if ((op_ff.opcode == OP_REMOVE) && delete_mode) begin
                  state_in = S_CL_READ;
               end else begin
                  state_in = S_DONE;
               end
            end else if (walk_last) begin
               state_in = S_DONE;
            end
         end
         S_CL_READ: begin
            state_in = S_CL_EVAL;
         end
         S_CL_EVAL: begin
            case (rd.mark)
               MARK_DELETED: state_in = cl_last ? S_DONE : S_CL_READ;
               MARK_FULL:    state_in = S_MV_HOME;
               default:      state_in = S_DONE;
            endcase
         end
         S_MV_HOME: begin
            if (home_done) begin
               state_in = S_MV_WALK;
            end
         end
         S_MV_WALK: begin
            if (hit_empty) begin
               state_in = cl_last ? S_DONE : S_CL_READ;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Outputs and datapath register updates.
   always_comb begin
      req_stall     = 1'b1;
      home_start    = 1'b0;
      home_key      = req_payload.key;
      raddr         = '0;
      waddr         = p_ff;
      wr            = '0;
      op_in         = op_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      q_in          = q_ff;
      m_in          = m_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      mv_in         = mv_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_value_in  = res_value_ff;
      unique case (state_ff)
         S_CLEAR: begin
            // One slot mark cleared per cycle.
            waddr        = clr_ff;
            wr.mark_we   = 1'b1;
            wr.data.mark = MARK_EMPTY;
            clr_in       = clr_ff + AW'(1);
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in         = req_payload;
               res_status_in = ST_NOT_FOUND;
               res_slot_in   = '0;
               res_value_in  = '0;
               home_start    = req_op_ok;
            end
         end
         S_HOME: begin
            if (home_done) begin
               raddr = home_addr;
               p_in  = home_addr;
               n_in  = '0;
            end
         end
         S_WALK: begin
            // The next slot is read ahead while this one is examined.
            raddr = nxt(p_ff);
            p_in  = nxt(p_ff);
            n_in  = n_ff + AW'(1);
            if (hit_empty) begin
               if (op_ff.opcode == OP_INSERT) begin
                  wr.mark_we    = 1'b1;
                  wr.kv_we      = 1'b1;
                  wr.data.mark  = MARK_FULL;
                  wr.data.key   = op_ff.key;
                  wr.data.value = op_ff.value;
                  count_in      = count_ff + CW'(1);
                  res_status_in = ST_OK;
                  res_slot_in   = p_ff;
               end
            end else if (hit_key) begin
               case (op_ff.opcode)
                  OP_FIND: begin
                     res_status_in = ST_OK;
                     res_slot_in   = p_ff;
                     res_value_in  = rd.value;
                  end
                  OP_INSERT: begin
                     res_status_in = ST_DUPLICATE;
                  end
                  OP_REMOVE: begin
                     res_status_in = ST_OK;
                     res_slot_in   = p_ff;
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                     end
                     wr.mark_we   = 1'b1;
                     wr.data.mark = delete_mode ? MARK_EMPTY : MARK_DELETED;
                     q_in         = nxt(p_ff);
                     m_in         = AW'(1);
                  end
                  default: begin
                  end
               endcase
            end else if (walk_last) begin
               if (op_ff.opcode == OP_INSERT) begin
                  res_status_in = ST_FULL;
               end
            end
         end
         S_CL_READ: begin
            raddr = q_ff;
         end
         S_CL_EVAL: begin
            // Tombstones are dropped; full entries are lifted out for placing again.
            waddr = q_ff;
            if ((rd.mark == MARK_DELETED) || (rd.mark == MARK_FULL)) begin
               wr.mark_we   = 1'b1;
               wr.data.mark = MARK_EMPTY;
            end
            if (rd.mark == MARK_FULL) begin
               mv_in      = rd;
               home_start = 1'b1;
               home_key   = rd.key;
            end else if (rd.mark == MARK_DELETED) begin
               q_in = nxt(q_ff);
               m_in = m_ff + AW'(1);
            end
         end
         S_MV_HOME: begin
            if (home_done) begin
               raddr = home_addr;
               p_in  = home_addr;
            end
         end
         S_MV_WALK: begin
            raddr = nxt(p_ff);
            p_in  = nxt(p_ff);
            if (hit_empty) begin
               wr.mark_we    = 1'b1;
               wr.kv_we      = 1'b1;
               wr.data.mark  = MARK_FULL;
               wr.data.key   = mv_ff.key;
               wr.data.value = mv_ff.value;
               q_in          = nxt(q_ff);
               m_in          = m_ff + AW'(1);
            end
         end
         S_DONE: begin
         end
      endcase
   end

   // Response register: loaded once the previous response has been taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = res_status_ff;
         rsp_in.slot        = SLOT_W'(res_slot_ff);
         rsp_in.found_value = res_value_ff;
         rsp_in.occupied    = OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      p_ff          <= p_in;
      n_ff          <= n_in;
      q_ff          <= q_in;
      m_ff          <= m_in;
      mv_ff         <= mv_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_value_ff  <= res_value_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> design/lpht_checker.sv
// Port-level checker of the hash table and its bind to the top level.
`timescale 1ns / 1ps
`include "linear_probe_hash_table_macros.svh"

module lpht_checker
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   logic rsp_failed;
   logic rsp_clean;
   logic occ_in_range;
   logic req_taken;

   assign rsp_failed   = rsp_valid && (rsp_payload.status != ST_OK);
   assign rsp_clean    = (rsp_payload.slot == '0) && (rsp_payload.found_value == '0);
   assign occ_in_range = (TABLE_SLOTS >= 128) || (rsp_payload.occupied <= TABLE_SLOTS);
   assign req_taken    = req_valid && !req_stall && (req_payload.key == req_payload.key);

   // A failed operation reports no slot and no value.
   `LPHT_ASSERT_SAME(a_fail_clean, rsp_failed, rsp_clean)

   // The live count never exceeds the table size; checked for tables under 128 slots.
   `LPHT_ASSERT_SAME(a_occ_bound, rsp_valid, occ_in_range)

   // Requests are worked one at a time: an accepted request stalls the next one.
   `LPHT_ASSERT_NEXT(a_one_at_a_time, req_taken, req_stall)

   // A stalled response stays offered and unchanged.
   `LPHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind linear_probe_hash_table lpht_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_checker (.*);

>>> tb/sv/linear_probe_hash_table_test.sv
// Self-checking testbench of the linear probing hash table.
`timescale 1ns / 1ps

module linear_probe_hash_table_test;
   import lpht_pkg::*;

   localparam int SLOTS     = DEFAULT_TABLE_SLOTS;
   localparam int POOL_SIZE = 100;
   localparam int LIMIT     = 20000000;
   localparam int HOLD_LEN  = 300;

   // Opcode that the block leaves unused, and the byte address of the mode register.
   localparam logic [1:0]            OP_UNUSED        = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] DELETE_MODE_ADDR = CSR_ADDR_W'(4 * CSR_DELETE_MODE);

   // Predicts every response from its own copy of the slot store.
   class table_scoreboard;
      mark_type           marks[SLOTS];
      logic [KEY_W-1:0]   keys[SLOTS];
      logic [VALUE_W-1:0] vals[SLOTS];
      int                 live;
      bit                 delete_mode;
      rsp_type            pending_responses[$];
      int                 errors;

      function new();
         foreach (marks[i]) marks[i] = MARK_EMPTY;
         live        = 0;
         delete_mode = 0;
         errors      = 0;
      endfunction

      function int count_marks(mark_type m);
         int n;
         n = 0;
         foreach (marks[i]) if (marks[i] == m) n++;
         return n;
      endfunction

      // Walks from the home slot to a full slot holding the key.
      function bit locate(logic [KEY_W-1:0] key, output int where);
         int p;
         bit hit;
         bit stop;
         p     = key % SLOTS;
         hit   = 0;
         stop  = 0;
         where = 0;
         for (int n = 0; n < SLOTS && !stop; n++) begin
            if (marks[p] == MARK_EMPTY) begin
               stop = 1;
            end else if (marks[p] == MARK_FULL && keys[p] == key) begin
               hit   = 1;
               stop  = 1;
               where = p;
            end else begin
               p = (p + 1) % SLOTS;
            end
         end
         return hit;
      endfunction

      // Walks from the home slot to the first empty slot; tombstones are passed over.
      function bit first_empty(logic [KEY_W-1:0] key, output int where);
         int p;
         bit hit;
         p     = key % SLOTS;
         hit   = 0;
         where = 0;
         for (int n = 0; n < SLOTS && !hit; n++) begin
            if (marks[p] == MARK_EMPTY) begin
               hit   = 1;
               where = p;
            end else begin
               p = (p + 1) % SLOTS;
            end
         end
         return hit;
      endfunction

      // Applies an accepted request and queues the response it must produce.
      function void note_request(req_type r);
         rsp_type            e;
         int                 p;
         int                 q;
         int                 dst;
         int                 n;
         logic [KEY_W-1:0]   k;
         logic [VALUE_W-1:0] v;
         e        = '0;
         e.status = ST_NOT_FOUND;
         case (r.opcode)
            OP_FIND: begin
               if (locate(r.key, p)) begin
                  e.status      = ST_OK;
                  e.slot        = SLOT_W'(p);
                  e.found_value = vals[p];
               end
            end
            OP_INSERT: begin
               if (locate(r.key, p)) begin
                  e.status = ST_DUPLICATE;
               end else if (first_empty(r.key, p)) begin
                  keys[p]  = r.key;
                  vals[p]  = r.value;
                  marks[p] = MARK_FULL;
                  live++;
                  e.status = ST_OK;
                  e.slot   = SLOT_W'(p);
               end else begin
                  e.status = ST_FULL;
               end
            end
            OP_REMOVE: begin
               if (locate(r.key, p)) begin
                  e.status = ST_OK;
                  e.slot   = SLOT_W'(p);
                  if (live > 0) live--;
                  if (!delete_mode) begin
                     marks[p] = MARK_DELETED;
                  end else begin
                     // Empty the slot, then drop tombstones and re-place entries
                     // along the rest of the cluster.
                     marks[p] = MARK_EMPTY;
                     q = (p + 1) % SLOTS;
                     for (n = 1; n < SLOTS && marks[q] != MARK_EMPTY; n++) begin
                        if (marks[q] == MARK_DELETED) begin
                           marks[q] = MARK_EMPTY;
                        end else begin
                           k        = keys[q];
                           v        = vals[q];
                           marks[q] = MARK_EMPTY;
                           void'(first_empty(k, dst));
                           keys[dst]  = k;
                           vals[dst]  = v;
                           marks[dst] = MARK_FULL;
                        end
                        q = (q + 1) % SLOTS;
                     end
                  end
               end
            end
            default: ;
         endcase
         e.occupied = OCC_W'(live);
         pending_responses.push_back(e);
      endfunction

      function int field_diff(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
         end
         return 0;
      endfunction

      // Compares an accepted response with the oldest expectation.
      function void check_response(rsp_type a);
         rsp_type e;
         if (pending_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %p", $time, a);
            errors++;
            return;
         end
         e = pending_responses.pop_front();
         errors += field_diff("status", e.status, a.status);
         errors += field_diff("slot", e.slot, a.slot);
         errors += field_diff("found_value", e.found_value, a.found_value);
         errors += field_diff("occupied", e.occupied, a.occupied);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   table_scoreboard  sb;
   logic [KEY_W-1:0] key_pool[POOL_SIZE];
   int               send_idle_pct;
   int               stall_pct;
   bit               hold_request;
   int               hold_left;
   int               cycle_count;

   linear_probe_hash_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // Clock generation.
   always #1 clock = ~clock;

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("linear_probe_hash_table regression: fail");
         $finish;
      end
   end

   // Receiver: random stalls, with a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_LEN;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
   end

   function automatic req_type make_request(logic [1:0] op, logic [KEY_W-1:0] key,
                                            logic [VALUE_W-1:0] value);
      req_type r;
      r.opcode = op;
      r.key    = key;
      r.value  = value;
      return r;
   endfunction

   // Random request, mostly on pooled keys so that hits, duplicates and clusters occur.
   // With tombstones in use, inserts and removes give way to finds before the table
   // runs out of empty or live slots.
   function automatic req_type random_request(int ins_pct, int rem_pct);
      req_type r;
      int      pick;
      pick    = $urandom_range(0, 99);
      r.value = $urandom;
      r.key   = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                            : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 3)                          r.opcode = OP_UNUSED;
      else if (pick < 3 + ins_pct)           r.opcode = OP_INSERT;
      else if (pick < 3 + ins_pct + rem_pct) r.opcode = OP_REMOVE;
      else                                   r.opcode = OP_FIND;
      if (!sb.delete_mode) begin
         if (r.opcode == OP_INSERT && sb.count_marks(MARK_EMPTY) < 4) r.opcode = OP_FIND;
         if (r.opcode == OP_REMOVE && sb.count_marks(MARK_FULL) < 8) r.opcode = OP_FIND;
      end
      return r;
   endfunction

   // Offers one request from a falling edge and returns at the falling edge after acceptance.
   task automatic send_request(req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      @(negedge clock);
   endtask

   // Lowers valid and waits until every expected response has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == DELETE_MODE_ADDR) sb.delete_mode = data[0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic run_phase(int count, int ins_pct, int rem_pct);
      for (int i = 0; i < count; i++) send_request(random_request(ins_pct, rem_pct));
      drain();
   endtask

   initial begin
      sb            = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      rsp_stall     = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 0;
      hold_left     = 0;
      cycle_count   = 0;

      // Key pool: homes crowd the start and the wrap-around end of the table.
      for (int i = 0; i < POOL_SIZE; i++) begin
         case (i % 3)
            0:       key_pool[i] = {25'($urandom), 6'($urandom_range(0, 7))};
            1:       key_pool[i] = {25'($urandom), 6'($urandom_range(58, 63))};
            default: key_pool[i] = {25'($urandom), 6'($urandom_range(0, 63))};
         endcase
      end
      key_pool[0] = '0;
      key_pool[1] = '1;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests with tombstones: collisions on slot 0, a walk that wraps past
      // the end, a duplicate, a tombstone skipped and not reused, and the unused opcode.
      csr_write(DELETE_MODE_ADDR, 32'd0);
      send_request(make_request(OP_INSERT, 31'd0, 32'h0000_0000));
      send_request(make_request(OP_INSERT, 31'd64, 32'hFFFF_FFFF));
      send_request(make_request(OP_INSERT, 31'd128, 32'h1234_5678));
      send_request(make_request(OP_INSERT, 31'h7FFF_FFFF, 32'hA5A5_A5A5));
      send_request(make_request(OP_INSERT, 31'd63, 32'h5A5A_5A5A));
      send_request(make_request(OP_FIND, 31'd63, 32'h0));
      send_request(make_request(OP_FIND, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_request(OP_INSERT, 31'd64, 32'h0BAD_0BAD));
      send_request(make_request(OP_REMOVE, 31'd64, 32'h0));
      send_request(make_request(OP_FIND, 31'd128, 32'h0));
      send_request(make_request(OP_FIND, 31'd64, 32'h0));
      send_request(make_request(OP_INSERT, 31'd64, 32'h0000_0001));
      send_request(make_request(OP_UNUSED, 31'd0, 32'hFFFF_FFFF));
      send_request(make_request(OP_REMOVE, 31'd999, 32'h0));
      send_request(make_request(OP_FIND, 31'd0, 32'h0));
      drain();

      // Directed requests with cluster reinsertion, including one that wraps.
      csr_write(DELETE_MODE_ADDR, 32'd1);
      send_request(make_request(OP_REMOVE, 31'd0, 32'h0));
      send_request(make_request(OP_FIND, 31'd128, 32'h0));
      send_request(make_request(OP_FIND, 31'd63, 32'h0));
      send_request(make_request(OP_FIND, 31'd64, 32'h0));
      send_request(make_request(OP_REMOVE, 31'h7FFF_FFFF, 32'h0));
      send_request(make_request(OP_FIND, 31'd63, 32'h0));
      send_request(make_request(OP_REMOVE, 31'd63, 32'h0));
      send_request(make_request(OP_FIND, 31'd128, 32'h0));
      drain();

      // Insert-heavy phase that fills the table, opening with a long receiver hold-off.
      @(posedge clock);
      hold_request = 1;
      @(negedge clock);
      run_phase(260, 60, 10);

      // Remove-heavy phase with an idle sender.
      send_idle_pct = 56;
      stall_pct     = 0;
      run_phase(260, 30, 40);

      // Tombstone phase with a stalling receiver.
      csr_write(DELETE_MODE_ADDR, 32'd0);
      send_idle_pct = 0;
      stall_pct     = 56;
      run_phase(260, 40, 25);

      // Reinsertion again, both sides idling.
      csr_write(DELETE_MODE_ADDR, 32'd1);
      send_idle_pct = 24;
      stall_pct     = 24;
      run_phase(260, 35, 35);

      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("linear_probe_hash_table regression: pass");
      end else begin
         $display("linear_probe_hash_table regression: fail");
      end
      $finish;
   end

endmodule
